// ===== src/ibq_pkg.sv =====
// ----------------------------------------------------------------------------
// ibq_pkg
// Shared types, register map and reset constants for the biquad sensor filter.
// ----------------------------------------------------------------------------
package ibq_pkg;

    localparam int MAX_ORDER_DEF = 2;

    localparam int SAMPLE_W   = 32;
    localparam int COEF_W     = 32;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    // five exact products need three guard bits beyond one product
    localparam int ACC_W      = PROD_W + 3;
    localparam int FRAC_SHIFT = 30;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_ORDER = 3'd0,
        REG_B0    = 3'd1,
        REG_B1    = 3'd2,
        REG_B2    = 3'd3,
        REG_A1    = 3'd4,
        REG_A2    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

    localparam logic [1:0]               ORDER_RST = 2'd2;
    localparam logic signed [COEF_W-1:0] B0_RST    = 32'sd259157;
    localparam logic signed [COEF_W-1:0] B1_RST    = 32'sd518315;
    localparam logic signed [COEF_W-1:0] B2_RST    = 32'sd259157;
    localparam logic signed [COEF_W-1:0] A1_RST    = -32'sd2099786147;
    localparam logic signed [COEF_W-1:0] A2_RST    = 32'sd1027080953;

endpackage

// ===== src/iir_biquad_sensor_filter.sv =====
// ----------------------------------------------------------------------------
// iir_biquad_sensor_filter
// Direct-form I IIR filter (order 1 or 2) for sensor samples, APB coefficients.
// ----------------------------------------------------------------------------
// A sample accepted into the input register r_x is registered into r_y and
// shows on o_sample_out. Throughput: one sample per cycle while the output is not
// stalled; the output-history feedback and the five products close combinationally
// between the input and result registers. Reset (synchronous, active low): clears
// both valids and the primed flag and loads the default coefficients and order;
// histories refill from the first sample.
module iir_biquad_sensor_filter #(
    parameter int MAX_ORDER = ibq_pkg::MAX_ORDER_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [ibq_pkg::SAMPLE_W-1:0]   i_sample_in,

    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [ibq_pkg::SAMPLE_W-1:0]   o_sample_out,

    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ibq_pkg::CFG_ADDR_W-1:0]        paddr,
    input  logic [ibq_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [ibq_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    localparam int SW         = ibq_pkg::SAMPLE_W;
    localparam int HIST_DEPTH = (MAX_ORDER < 2) ? 1 : 2;

    logic [1:0]            r_order;
    ibq_pkg::t_coefs       r_coefs;

    logic                  r_in_valid;
    logic signed [SW-1:0]  r_x;
    logic                  r_out_valid;
    logic signed [SW-1:0]  r_y;
    logic                  r_primed;
    logic signed [SW-1:0]  r_xh [HIST_DEPTH];
    logic signed [SW-1:0]  r_yh [HIST_DEPTH];

    logic                  in_take;
    logic                  advance;
    logic                  cfg_wr;
    ibq_pkg::t_reg_idx     reg_idx;
    logic                  tap2_en;
    logic signed [SW-1:0]  e_x1, e_x2, e_y1, e_y2;
    logic signed [SW-1:0]  n_y;

    // ---------------- configuration ----------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = ibq_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order    <= ibq_pkg::ORDER_RST;
            r_coefs.b0 <= ibq_pkg::B0_RST;
            r_coefs.b1 <= ibq_pkg::B1_RST;
            r_coefs.b2 <= ibq_pkg::B2_RST;
            r_coefs.a1 <= ibq_pkg::A1_RST;
            r_coefs.a2 <= ibq_pkg::A2_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                ibq_pkg::REG_ORDER: r_order    <= pwdata[1:0];
                ibq_pkg::REG_B0:    r_coefs.b0 <= pwdata;
                ibq_pkg::REG_B1:    r_coefs.b1 <= pwdata;
                ibq_pkg::REG_B2:    r_coefs.b2 <= pwdata;
                ibq_pkg::REG_A1:    r_coefs.a1 <= pwdata;
                ibq_pkg::REG_A2:    r_coefs.a2 <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ibq_pkg::REG_ORDER: prdata = {{(ibq_pkg::CFG_DATA_W-2){1'b0}}, r_order};
            ibq_pkg::REG_B0:    prdata = r_coefs.b0;
            ibq_pkg::REG_B1:    prdata = r_coefs.b1;
            ibq_pkg::REG_B2:    prdata = r_coefs.b2;
            ibq_pkg::REG_A1:    prdata = r_coefs.a1;
            ibq_pkg::REG_A2:    prdata = r_coefs.a2;
            default:            prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_primed    <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_primed    <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_x <= i_sample_in;
        end
        if (advance) begin
            r_y <= n_y;
        end
    end

    // ---------------- histories ----------------
    // before the first sample the histories read as that sample
    assign e_x1 = r_primed ? r_xh[0] : r_x;
    assign e_y1 = r_primed ? r_yh[0] : r_x;

    generate
        if (HIST_DEPTH >= 2) begin : g_tap2
            assign e_x2 = r_primed ? r_xh[1] : r_x;
            assign e_y2 = r_primed ? r_yh[1] : r_x;
        end else begin : g_no_tap2
            assign e_x2 = '0;
            assign e_y2 = '0;
        end
    endgenerate

    assign tap2_en = (r_order >= 2'd2) && (MAX_ORDER >= 2);

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_xh[0] <= r_x;
            r_yh[0] <= n_y;
            for (int k = 1; k < HIST_DEPTH; k++) begin
                r_xh[k] <= r_primed ? r_xh[k-1] : r_x;
                r_yh[k] <= r_primed ? r_yh[k-1] : r_x;
            end
        end
    end

    ibq_mac u_mac (
        .i_x       (r_x),
        .i_x1      (e_x1),
        .i_x2      (e_x2),
        .i_y1      (e_y1),
        .i_y2      (e_y2),
        .i_coefs   (r_coefs),
        .i_tap2_en (tap2_en),
        .o_y       (n_y)
    );

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_y;

endmodule

// ===== src/ibq_mac.sv =====
// ----------------------------------------------------------------------------
// ibq_mac
// One-pass direct-form I sum of five exact products, rounding and saturation.
// ----------------------------------------------------------------------------
module ibq_mac (
    input  logic signed [ibq_pkg::SAMPLE_W-1:0] i_x,
    input  logic signed [ibq_pkg::SAMPLE_W-1:0] i_x1,
    input  logic signed [ibq_pkg::SAMPLE_W-1:0] i_x2,
    input  logic signed [ibq_pkg::SAMPLE_W-1:0] i_y1,
    input  logic signed [ibq_pkg::SAMPLE_W-1:0] i_y2,
    input  ibq_pkg::t_coefs                     i_coefs,
    input  logic                                i_tap2_en,
    output logic signed [ibq_pkg::SAMPLE_W-1:0] o_y
);

    localparam int PW  = ibq_pkg::PROD_W;
    localparam int AW  = ibq_pkg::ACC_W;
    localparam int SW  = ibq_pkg::SAMPLE_W;
    localparam int FS  = ibq_pkg::FRAC_SHIFT;
    localparam int YW  = AW - FS;

    logic signed [ibq_pkg::COEF_W-1:0] b2_g;
    logic signed [ibq_pkg::COEF_W-1:0] a2_g;
    logic signed [PW-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [AW-1:0] sum;
    logic signed [AW-1:0] rnd;
    logic signed [YW-1:0] y_wide;

    // drop the second tap when the filter runs at order zero or one
    assign b2_g = i_tap2_en ? i_coefs.b2 : '0;
    assign a2_g = i_tap2_en ? i_coefs.a2 : '0;

    assign p_b0 = PW'(i_coefs.b0) * PW'(i_x);
    assign p_b1 = PW'(i_coefs.b1) * PW'(i_x1);
    assign p_b2 = PW'(b2_g)       * PW'(i_x2);
    assign p_a1 = PW'(i_coefs.a1) * PW'(i_y1);
    assign p_a2 = PW'(a2_g)       * PW'(i_y2);

    assign sum = AW'(p_b0) + AW'(p_b1) + AW'(p_b2) - AW'(p_a1) - AW'(p_a2);

    // add half an LSB, then floor: ties go toward plus infinity
    assign rnd    = sum + (AW'(1) <<< (FS - 1));
    assign y_wide = rnd[AW-1:FS];

    always_comb begin
        if (y_wide[YW-1:SW-1] == '0 || y_wide[YW-1:SW-1] == '1) begin
            o_y = y_wide[SW-1:0];
        end else if (y_wide[YW-1]) begin
            o_y = {1'b1, {(SW-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(SW-1){1'b1}}};
        end
    end

endmodule

// ===== src/ibq_chk.sv =====
// ----------------------------------------------------------------------------
// ibq_chk
// Port-level checks for the biquad sensor filter, bound to the top level.
// ----------------------------------------------------------------------------
module ibq_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic                                i_stall,
    input logic signed [ibq_pkg::SAMPLE_W-1:0] o_sample_out,
    input logic                                pready
);

    // hold: a result waiting downstream keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_sample_out)))
        else $error("stalled result changed or dropped");

    // stall upstream only when a result is blocked downstream
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // a result leaves only through a completed transaction
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_valid) && $past(i_rst_n)) |-> !$past(i_stall))
        else $error("result dropped without a transaction");

    // an item taken while the output is free is followed by a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !o_valid) |=> ##1 o_valid)
        else $error("accepted item produced no result");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready low");

endmodule

bind iir_biquad_sensor_filter ibq_chk u_ibq_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_sample_out (o_sample_out),
    .pready       (pready)
);

// ===== dv/iir_biquad_sensor_filter_test.sv =====
// ----------------------------------------------------------------------------
// iir_biquad_sensor_filter_test
// Self-checking bench for the direct-form I biquad sensor filter. Samples go
// in through a bursty driver and results come out through a stalling
// monitor. Each result is checked against a bit-exact fixed-point filter
// kept here, under a series of coefficient and order settings written
// through the APB port.
// ----------------------------------------------------------------------------
module iir_biquad_sensor_filter_test;

    localparam int FILTER_TAPS = ibq_pkg::MAX_ORDER_DEF;
    localparam int RANDOM_SETS = 8;
    localparam int SET_SAMPLES = 50;
    localparam int PRINT_CAP   = 40;
    localparam int HOLD_CYCLES = 60;

    // register slots past the end of the map
    localparam logic [2:0] REG_SPARE_6 = 3'd6;
    localparam logic [2:0] REG_SPARE_7 = 3'd7;

    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
    localparam logic signed [31:0] Q30_HALF = 32'sh2000_0000;

    typedef enum int {
        STYLE_RESET,
        STYLE_LOWPASS,
        STYLE_RANDOM,
        STYLE_EXTREME,
        STYLE_ORDER_ONLY
    } t_cfg_style;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic signed [ibq_pkg::SAMPLE_W-1:0] i_sample_in = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic signed [ibq_pkg::SAMPLE_W-1:0] o_sample_out;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [ibq_pkg::CFG_ADDR_W-1:0]      paddr = '0;
    logic [ibq_pkg::CFG_DATA_W-1:0]      pwdata = '0;
    logic [ibq_pkg::CFG_DATA_W-1:0]      prdata;
    logic                                pready;

    iir_biquad_sensor_filter DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample_in  (i_sample_in),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_sample_out (o_sample_out),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #1 i_clk = ~i_clk;

    // filter state mirrored on this side
    logic [1:0]         cfg_order = ibq_pkg::ORDER_RST;
    logic signed [31:0] cfg_b0 = ibq_pkg::B0_RST;
    logic signed [31:0] cfg_b1 = ibq_pkg::B1_RST;
    logic signed [31:0] cfg_b2 = ibq_pkg::B2_RST;
    logic signed [31:0] cfg_a1 = ibq_pkg::A1_RST;
    logic signed [31:0] cfg_a2 = ibq_pkg::A2_RST;
    logic signed [31:0] past_in [FILTER_TAPS];
    logic signed [31:0] past_out [FILTER_TAPS];
    bit                 histories_primed = 1'b0;

    logic signed [31:0] sample_queue [$];
    logic signed [31:0] expected_out [$];

    int mismatches = 0;
    int samples_pushed = 0;
    int samples_accepted = 0;
    int results_seen = 0;
    int clipped_results = 0;
    int settings_used = 0;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < PRINT_CAP)
            $display("MISMATCH %s: got %08h, expected %08h", what, got, want);
        mismatches++;
    endtask

    // exact sum of products, round half up while dropping 30 fraction bits, saturate, then shift histories
    function automatic logic signed [31:0] filter_sample(logic signed [31:0] x);
        logic signed [127:0] acc;
        logic signed [127:0] rounded;
        logic signed [31:0]  y;
        int                  taps;
        taps = (cfg_order == 2'd0) ? 1 : (int'(cfg_order) > FILTER_TAPS) ? FILTER_TAPS
                                                                         : int'(cfg_order);
        if (!histories_primed) begin
            for (int k = 0; k < FILTER_TAPS; k++) begin
                past_in[k] = x;
                past_out[k] = x;
            end
            histories_primed = 1'b1;
        end
        acc = longint'(cfg_b0) * longint'(x);
        acc = acc + longint'(cfg_b1) * longint'(past_in[0]);
        acc = acc - longint'(cfg_a1) * longint'(past_out[0]);
        if (taps >= 2) begin
            acc = acc + longint'(cfg_b2) * longint'(past_in[1]);
            acc = acc - longint'(cfg_a2) * longint'(past_out[1]);
        end
        rounded = (acc + (128'sd1 <<< (ibq_pkg::FRAC_SHIFT - 1))) >>> ibq_pkg::FRAC_SHIFT;
        if (rounded > 128'sd2147483647) begin
            y = S_MAX;
            clipped_results++;
        end else if (rounded < -128'sd2147483648) begin
            y = S_MIN;
            clipped_results++;
        end else begin
            y = rounded[31:0];
        end
        for (int k = FILTER_TAPS - 1; k > 0; k--) begin
            past_in[k] = past_in[k-1];
            past_out[k] = past_out[k-1];
        end
        past_in[0] = x;
        past_out[0] = y;
        return y;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts of transactions with random gaps in between
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_out.push_back(filter_sample(i_sample_in));
                samples_accepted++;
            end
            // hold a stalled transaction as it is
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (sample_queue.size() > 0) begin
                    i_valid <= 1'b1;
                    i_sample_in <= sample_queue.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results and stall on a pattern of its own
    // ------------------------------------------------------------------
    logic signed [31:0] want_sample;
    int stall_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    int holds_done = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_out.size() == 0) begin
                    report_mismatch("unexpected sample_out", o_sample_out, '0);
                end else begin
                    want_sample = expected_out.pop_front();
                    if (o_sample_out !== want_sample)
                        report_mismatch("sample_out", o_sample_out, want_sample);
                end
                results_seen++;
            end
            // long hold-off so the block fills and stalls its input
            if (hold_left == 0 && holds_done < 2 && results_seen >= 120 + 180 * holds_done) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 96);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                case (stall_mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ~i_stall;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Register access
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] wdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ibq_pkg::REG_ORDER: cfg_order = wdata[1:0];
            ibq_pkg::REG_B0:    cfg_b0 = wdata;
            ibq_pkg::REG_B1:    cfg_b1 = wdata;
            ibq_pkg::REG_B2:    cfg_b2 = wdata;
            ibq_pkg::REG_A1:    cfg_a1 = wdata;
            ibq_pkg::REG_A2:    cfg_a2 = wdata;
            default: ;
        endcase
    endtask

    task automatic verify_registers();
        logic [2:0]  idx;
        logic [31:0] want;
        for (int i = 0; i <= int'(ibq_pkg::REG_A2); i++) begin
            idx = 3'(i);
            case (idx)
                ibq_pkg::REG_ORDER: want = {30'd0, cfg_order};
                ibq_pkg::REG_B0:    want = cfg_b0;
                ibq_pkg::REG_B1:    want = cfg_b1;
                ibq_pkg::REG_B2:    want = cfg_b2;
                ibq_pkg::REG_A1:    want = cfg_a1;
                default:            want = cfg_a2;
            endcase
            @(posedge i_clk);
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= {idx, 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            if (prdata !== want)
                report_mismatch($sformatf("register %0d readback", i), prdata, want);
            psel <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic write_all(logic [1:0] order, logic signed [31:0] b0, logic signed [31:0] b1,
                             logic signed [31:0] b2, logic signed [31:0] a1,
                             logic signed [31:0] a2);
        write_reg(ibq_pkg::REG_ORDER, {30'd0, order});
        write_reg(ibq_pkg::REG_B0, b0);
        write_reg(ibq_pkg::REG_B1, b1);
        write_reg(ibq_pkg::REG_B2, b2);
        write_reg(ibq_pkg::REG_A1, a1);
        write_reg(ibq_pkg::REG_A2, a2);
        settings_used++;
    endtask

    function automatic logic signed [31:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return S_MAX;
            1: return S_MIN;
            2: return 32'sd0;
            3: return 32'sd1;
            4: return -32'sd1;
            default: return Q30_ONE;
        endcase
    endfunction

    task automatic push_sample(logic signed [31:0] x);
        sample_queue.push_back(x);
        samples_pushed++;
    endtask

    // drain everything, then pause before the next setting
    task automatic wait_idle();
        while (samples_accepted != samples_pushed || expected_out.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic configure_random();
        t_cfg_style         style;
        logic signed [31:0] k;
        style = t_cfg_style'($urandom_range(0, 4));
        case (style)
            STYLE_RESET: begin
                write_all(2'($urandom_range(0, 3)), ibq_pkg::B0_RST, ibq_pkg::B1_RST,
                          ibq_pkg::B2_RST, ibq_pkg::A1_RST, ibq_pkg::A2_RST);
            end
            STYLE_LOWPASS: begin
                // first-order low-pass: b0 = b1 = k, pole at 1 - 2k
                k = $urandom_range(1, 1 << 27);
                write_all(2'($urandom_range(0, 1)), k, k, $urandom, (k <<< 1) - Q30_ONE,
                          $urandom);
            end
            STYLE_RANDOM: begin
                write_all(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            end
            STYLE_EXTREME: begin
                write_all(2'($urandom_range(0, 3)), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), pick_extreme());
            end
            default: begin
                // change the order alone, histories carry on
                write_reg(ibq_pkg::REG_ORDER, 32'($urandom_range(0, 3)));
                settings_used++;
            end
        endcase
    endtask

    function automatic logic signed [31:0] next_random_sample(logic signed [31:0] prev);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return prev + 32'($signed(13'($urandom)));
            4, 5, 6:    return $urandom;
            7:          return pick_extreme();
            default:    return 32'($signed(18'($urandom)));
        endcase
    endfunction

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic signed [31:0] last_sample;
        last_sample = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        verify_registers();
        settings_used++;

        // reset coefficients; the first sample primes both histories
        push_sample(S_MAX);
        push_sample(S_MAX);
        push_sample(S_MIN);
        push_sample(S_MIN);
        push_sample(32'sd0);
        push_sample(-32'sd1);
        push_sample(32'sd1);
        push_sample(32'sh0001_0000);
        wait_idle();

        // half-LSB ties round toward plus infinity
        write_all(2'd1, Q30_HALF, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        verify_registers();
        push_sample(32'sd1);
        push_sample(-32'sd1);
        push_sample(32'sd3);
        push_sample(-32'sd3);
        push_sample(32'sd0);
        wait_idle();

        // extreme coefficients and samples drive the output into saturation
        write_all(2'd2, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX);
        verify_registers();
        push_sample(S_MAX);
        push_sample(S_MIN);
        push_sample(S_MAX);
        push_sample(S_MIN);
        push_sample(32'sd0);
        push_sample(-32'sd1);
        wait_idle();

        // order 0 behaves as 1, order 3 as 2; spare register slots are ignored
        write_all(2'd0, Q30_HALF, 32'sh1000_0000, 32'sh0800_0000, 32'shE000_0000,
                  32'sh0400_0000);
        write_reg(REG_SPARE_6, 32'hDEAD_BEEF);
        write_reg(REG_SPARE_7, 32'h5555_AAAA);
        verify_registers();
        push_sample(32'sh0002_8000);
        push_sample(-32'sh0001_4000);
        push_sample(32'sh0000_C000);
        wait_idle();
        write_reg(ibq_pkg::REG_ORDER, 32'd3);
        verify_registers();
        push_sample(32'sh0003_0000);
        push_sample(-32'sh0002_0000);
        push_sample(32'sh0001_0000);
        wait_idle();

        for (int set = 0; set < RANDOM_SETS; set++) begin
            configure_random();
            verify_registers();
            for (int n = 0; n < SET_SAMPLES; n++) begin
                last_sample = next_random_sample(last_sample);
                push_sample(last_sample);
            end
            wait_idle();
        end

        $display("Filtered %0d samples under %0d register settings, %0d results clipped.",
                 samples_accepted, settings_used, clipped_results);
        $display("Checked %0d results with %0d long output hold-offs; %0d mismatches.",
                 results_seen, holds_done, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== iir_biquad_sensor_filter.f =====
src/ibq_pkg.sv
src/ibq_mac.sv
src/iir_biquad_sensor_filter.sv
src/ibq_chk.sv
dv/iir_biquad_sensor_filter_test.sv
